// ===== rtl/swts_pkg.sv =====
`default_nettype none

package swts_pkg;

	localparam int WINDOW = 64;
	localparam int TIME_WIDTH = 32;
	localparam int POS_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);

	// Fixed register field widths
	localparam int LEN_W = 7;
	localparam int CUT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CUT_W-1:0] cut_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_WINDOW_LENGTH = 1'b0;
	localparam cfg_idx_t CFG_CUT_COUNT = 1'b1;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_PASS,
		ST_FINISH,
		ST_OUT
	} state_t;

	// Sorted positions of the three reported samples
	typedef struct packed {
		pos_t tmin;
		pos_t tmax;
		pos_t tmed;
	} tgt_t;

	// Rank unit result for one stored entry
	typedef struct packed {
		pos_t rank;
		logic below;
		logic hit_min;
		logic hit_max;
		logic hit_med;
	} upd_t;

	function automatic cnt_t clamp_length(input logic [LEN_W-1:0] v);
		cnt_t r;
		if (v == '0) begin
			r = cnt_t'(1);
		end else if (int'(v) > WINDOW) begin
			r = cnt_t'(WINDOW);
		end else begin
			r = cnt_t'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/sliding_window_trimmed_stats.sv =====
`default_nettype none

// Trimmed order statistics over the most recent window_length samples.
// Each transfer on the s_axis side either adds a sample or clears the history,
// and each yields exactly one result on m_axis: the sample at sorted position
// cut_count, at count-1-cut_count and at count/2, or zeros with has_metrics low
// when count <= 2*cut_count. Samples sit in a 64-entry history memory next to a
// rank memory holding each sample's sorted position; an add runs one rank
// update pass over the window, one entry per cycle through a single compare
// unit. An add steps through the WRITE, PASS, FINISH and OUT states, a clear
// through OUT alone (count = samples after the add, at most 64); the result
// is registered on m_axis on leaving OUT, which waits while the previous
// result still waits on m_axis_tready. s_axis_tready is low while an item is
// in work and rises again in the cycle its result is presented.
// Configuration transfers are taken while idle; writing a new window_length
// empties the history. No clearing pass follows reset.
module sliding_window_trimmed_stats (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // sample_time
	input  wire  [0:0]  s_axis_tuser,   // func
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [95:0] m_axis_tdata,   // trimmed_min, trimmed_max, median
	output logic [0:0]  m_axis_tuser,   // has_metrics
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  swts_pkg::cfg_idx_t cfg_index,
	input  wire  [swts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swts_pkg::*;

	state_t state_q;
	state_t state_nx;

	cnt_t   win_len_q;
	cut_t   cut_q;
	cnt_t   fill_q;
	pos_t   write_pos_q;

	time_t  x_q;
	time_t  old_q;
	pos_t   p_q;
	logic   full_q;
	cnt_t   n_q;
	tgt_t   tgt_q;
	logic   has_q;
	cnt_t   idx_q;
	pos_t   cnt_q;
	time_t  min_q;
	time_t  max_q;
	time_t  med_q;

	logic   vld_s1;
	pos_t   j_s1;

	time_t  hist_mem [WINDOW];
	pos_t   rank_mem [WINDOW];
	time_t  hist_rd_q;
	pos_t   rank_rd_q;
	pos_t   hist_raddr;

	logic   in_xfer;
	logic   cfg_xfer;
	logic   out_free;
	logic   issue;
	logic   pass_done;
	logic   upd_en;
	upd_t   upd;

	cnt_t   n_new;
	cnt_t   len_new;

	swts_rank_unit u_rank (
		.sample     (x_q),
		.sample_pos (p_q),
		.old_sample (old_q),
		.remove     (full_q),
		.entry      (hist_rd_q),
		.entry_pos  (j_s1),
		.entry_rank (rank_rd_q),
		.tgt        (tgt_q),
		.upd        (upd)
	);

	// Handshake and sequencing strobes
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
		cfg_ready = (state_q == ST_IDLE);
		in_xfer = s_axis_tvalid && s_axis_tready;
		cfg_xfer = cfg_valid && cfg_ready;
		out_free = !m_axis_tvalid || m_axis_tready;
		issue = (state_q == ST_PASS) && (idx_q < n_q);
		pass_done = (state_q == ST_PASS) && !issue && !vld_s1;
		upd_en = vld_s1 && (j_s1 != p_q);
		hist_raddr = (state_q == ST_IDLE) ? write_pos_q : idx_q[POS_W-1:0];
		n_new = full_q ? fill_q : fill_q + cnt_t'(1);
		len_new = clamp_length(cfg_data[LEN_W-1:0]);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_nx = (s_axis_tuser[0] == FUNC_CLEAR) ? ST_OUT : ST_WRITE;
				end
			end
			ST_WRITE: state_nx = ST_PASS;
			ST_PASS: begin
				if (pass_done) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: state_nx = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			win_len_q <= cnt_t'(WINDOW);
			cut_q <= '0;
			fill_q <= '0;
			write_pos_q <= '0;
			vld_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1 <= issue;
			if (cfg_xfer) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH: begin
						if (len_new != win_len_q) begin
							win_len_q <= len_new;
							fill_q <= '0;
							write_pos_q <= '0;
						end
					end
					CFG_CUT_COUNT: cut_q <= cfg_data[CUT_W-1:0];
					default: ;
				endcase
			end
			if (in_xfer && (s_axis_tuser[0] == FUNC_CLEAR)) begin
				fill_q <= '0;
				write_pos_q <= '0;
			end
			if (state_q == ST_WRITE) begin
				fill_q <= n_new;
				if (cnt_t'(write_pos_q) + cnt_t'(1) >= win_len_q) begin
					write_pos_q <= '0;
				end else begin
					write_pos_q <= write_pos_q + pos_t'(1);
				end
			end
			if ((state_q == ST_OUT) && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= s_axis_tdata;
			p_q <= write_pos_q;
			full_q <= (fill_q == win_len_q);
			has_q <= 1'b0;
		end
		if (state_q == ST_WRITE) begin
			old_q <= hist_rd_q;
			n_q <= n_new;
			has_q <= int'(n_new) > 2 * int'(cut_q);
			tgt_q.tmin <= pos_t'(cut_q);
			tgt_q.tmax <= pos_t'(n_new - cnt_t'(1) - cnt_t'(cut_q));
			tgt_q.tmed <= pos_t'(n_new >> 1);
			idx_q <= '0;
			cnt_q <= '0;
		end
		if (issue) begin
			idx_q <= idx_q + cnt_t'(1);
			j_s1 <= idx_q[POS_W-1:0];
		end
		if (upd_en) begin
			cnt_q <= cnt_q + pos_t'(upd.below);
			if (upd.hit_min) begin
				min_q <= hist_rd_q;
			end
			if (upd.hit_max) begin
				max_q <= hist_rd_q;
			end
			if (upd.hit_med) begin
				med_q <= hist_rd_q;
			end
		end
		if (state_q == ST_FINISH) begin
			if (cnt_q == tgt_q.tmin) begin
				min_q <= x_q;
			end
			if (cnt_q == tgt_q.tmax) begin
				max_q <= x_q;
			end
			if (cnt_q == tgt_q.tmed) begin
				med_q <= x_q;
			end
		end
		if ((state_q == ST_OUT) && out_free) begin
			m_axis_tuser[0] <= has_q;
			m_axis_tdata <= has_q ? {med_q, max_q, min_q} : '0;
		end
	end

	// History and rank memories
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE) begin
			hist_mem[p_q] <= x_q;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			rank_mem[j_s1] <= upd.rank;
		end else if (state_q == ST_FINISH) begin
			rank_mem[p_q] <= cnt_q;
		end
		rank_rd_q <= rank_mem[idx_q[POS_W-1:0]];
	end

`ifndef NO_ASSERTIONS
	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_len_q)
		else $error("fill count exceeds window length");

	a_ring_append: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != win_len_q) |-> (write_pos_q == fill_q[POS_W-1:0]))
		else $error("write position out of step with fill count");

	a_new_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> ({1'b0, cnt_q} < n_q))
		else $error("rank of new sample outside window");

	a_metrics_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
		((m_axis_tdata[31:0] <= m_axis_tdata[95:64]) &&
		 (m_axis_tdata[95:64] <= m_axis_tdata[63:32])))
		else $error("trimmed min, median, max out of order");

	a_no_metrics_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("nonzero result without metrics");
`endif

endmodule

`default_nettype wire

// ===== rtl/swts_rank_unit.sv =====
`default_nettype none

module swts_rank_unit (
	input  wire swts_pkg::time_t sample,
	input  wire swts_pkg::pos_t  sample_pos,
	input  wire swts_pkg::time_t old_sample,
	input  wire                  remove,
	input  wire swts_pkg::time_t entry,
	input  wire swts_pkg::pos_t  entry_pos,
	input  wire swts_pkg::pos_t  entry_rank,
	input  wire swts_pkg::tgt_t  tgt,
	output swts_pkg::upd_t       upd
);
	import swts_pkg::*;

	logic         ins_lt;
	logic         rem_lt;
	logic [POS_W:0] rank_ext;

	// Keys are (value, position) so ties order by ring position
	always_comb begin
		ins_lt = (sample < entry) || ((sample == entry) && (sample_pos < entry_pos));
		rem_lt = remove &&
			((old_sample < entry) || ((old_sample == entry) && (sample_pos < entry_pos)));
		rank_ext = {1'b0, entry_rank} + {{POS_W{1'b0}}, ins_lt} - {{POS_W{1'b0}}, rem_lt};
		upd.rank = rank_ext[POS_W-1:0];
		upd.below = ~ins_lt;
		upd.hit_min = (upd.rank == tgt.tmin);
		upd.hit_max = (upd.rank == tgt.tmax);
		upd.hit_med = (upd.rank == tgt.tmed);
	end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import swts_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic  has;
		time_t tmin;
		time_t tmax;
		time_t tmed;
	} win_stats_t;

	// Own copy of the window: ring, pointers, registers and the stats still owed
	class trimmed_window;
		time_t       ring [WINDOW];
		int unsigned wr_pos;
		int unsigned old_pos;
		int unsigned fill;
		int unsigned win_len;
		int unsigned cut;
		win_stats_t  owed_stats [$];
		int          mismatches;

		function new();
			wr_pos = 0;
			old_pos = 0;
			fill = 0;
			win_len = WINDOW;
			cut = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return owed_stats.size();
		endfunction

		task flag(input string msg);
			if (mismatches < 200) begin
				$display("mismatch: %s", msg);
			end
			mismatches++;
		endtask

		function void empty_ring();
			wr_pos = 0;
			old_pos = 0;
			fill = 0;
		endfunction

		function void write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
			int unsigned len;
			if (idx == CFG_WINDOW_LENGTH) begin
				len = 32'(data);
				if (len == 0) begin
					len = 1;
				end else if (len > WINDOW) begin
					len = WINDOW;
				end
				if (len != win_len) begin
					win_len = len;
					empty_ring();
				end
			end else begin
				cut = 32'(data[CUT_W-1:0]);
			end
		endfunction

		function win_stats_t summarize();
			time_t       sorted [WINDOW];
			time_t       v;
			int unsigned pos;
			int unsigned n;
			int          i;
			int          j;
			win_stats_t  r;
			r = '0;
			n = fill;
			if (n == 0) begin
				return r;
			end
			pos = old_pos;
			for (i = 0; i < n; i++) begin
				sorted[i] = ring[pos];
				pos++;
				if (pos >= win_len) begin
					pos = 0;
				end
			end
			for (i = 1; i < n; i++) begin
				v = sorted[i];
				j = i;
				while (j > 0 && sorted[j-1] > v) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = v;
			end
			if (n <= 2 * cut) begin
				return r;
			end
			r.has = 1'b1;
			r.tmin = sorted[cut];
			r.tmax = sorted[n-1-cut];
			r.tmed = sorted[n/2];
			return r;
		endfunction

		function void add_item(input logic func, input time_t sample);
			if (func == FUNC_CLEAR) begin
				empty_ring();
			end else begin
				ring[wr_pos] = sample;
				wr_pos++;
				if (wr_pos >= win_len) begin
					wr_pos = 0;
				end
				if (fill < win_len) begin
					fill++;
				end else begin
					old_pos = wr_pos;
				end
			end
			owed_stats.push_back(summarize());
		endfunction

		task compare_stats(input win_stats_t got);
			win_stats_t want;
			if (owed_stats.size() == 0) begin
				flag($sformatf("result with nothing owed: has=%0b min=%h max=%h med=%h",
					got.has, got.tmin, got.tmax, got.tmed));
				return;
			end
			want = owed_stats.pop_front();
			if (got.has !== want.has) begin
				flag($sformatf("has_metrics %b, want %b", got.has, want.has));
			end
			if (got.tmin !== want.tmin) begin
				flag($sformatf("trimmed_min %h, want %h", got.tmin, want.tmin));
			end
			if (got.tmax !== want.tmax) begin
				flag($sformatf("trimmed_max %h, want %h", got.tmax, want.tmax));
			end
			if (got.tmed !== want.tmed) begin
				flag($sformatf("median %h, want %h", got.tmed, want.tmed));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata;
	logic [0:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [95:0]           m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	trimmed_window window;
	int            send_idle_pct;
	int            recv_stall_pct;

	sliding_window_trimmed_stats i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task send_item(input logic func, input time_t sample);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			s_axis_tdata = $urandom;
			s_axis_tuser = 1'($urandom_range(0, 1));
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = sample;
		s_axis_tuser = func;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		window.add_item(func, sample);
	endtask

	task add_sample(input time_t sample);
		send_item(FUNC_ADD, sample);
	endtask

	// Hold the input side until every owed result has been taken
	task await_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (window.pending() > 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		await_results();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		window.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function time_t pick_sample();
		time_t v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2, 3: v = $urandom_range(0, 15);
			4: v = 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Result side: stall at the falling edge, take transfers at the rising edge
	initial begin
		win_stats_t got;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.has = m_axis_tuser[0];
				got.tmin = m_axis_tdata[31:0];
				got.tmax = m_axis_tdata[63:32];
				got.tmed = m_axis_tdata[95:64];
				window.compare_stats(got);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int          ph;
		int          seg;
		int          i;
		int unsigned len;
		int unsigned cut;
		logic        func;
		window = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_ADD;
		cfg_valid = 1'b0;
		cfg_index = CFG_WINDOW_LENGTH;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty window, extremes, too few samples, length edge cases, wrap
		send_item(FUNC_CLEAR, $urandom);
		add_sample(32'h0000_0000);
		add_sample(32'hFFFF_FFFF);
		add_sample(32'h5555_5555);
		add_sample(32'hAAAA_AAAA);
		set_reg(CFG_CUT_COUNT, 7'd3);
		add_sample(32'd7);
		add_sample(32'd1);
		add_sample(32'd9);
		send_item(FUNC_CLEAR, 32'hFFFF_FFFF);
		set_reg(CFG_CUT_COUNT, 7'd63);
		add_sample(32'h1234_5678);
		set_reg(CFG_CUT_COUNT, 7'd0);
		set_reg(CFG_WINDOW_LENGTH, 7'd0);
		add_sample(32'd10);
		add_sample(32'd20);
		add_sample(32'd5);
		set_reg(CFG_WINDOW_LENGTH, 7'd127);
		add_sample(32'd100);
		add_sample(32'd50);
		// same effective length: history stays
		set_reg(CFG_WINDOW_LENGTH, 7'd64);
		add_sample(32'd75);
		set_reg(CFG_WINDOW_LENGTH, 7'd3);
		add_sample(32'd3);
		add_sample(32'd1);
		add_sample(32'd4);
		add_sample(32'd1);
		add_sample(32'd5);
		set_reg(CFG_CUT_COUNT, 7'd1);
		add_sample(32'd9);
		send_item(FUNC_CLEAR, 32'd0);

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					send_idle_pct = 11;
					recv_stall_pct = 11;
				end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				case ($urandom_range(0, 5))
					0: len = $urandom_range(0, 1);
					1: len = 64;
					2: len = $urandom_range(65, 127);
					3: len = $urandom_range(2, 8);
					default: len = $urandom_range(1, 64);
				endcase
				set_reg(CFG_WINDOW_LENGTH, len[CFG_DATA_W-1:0]);
				case ($urandom_range(0, 5))
					0: cut = 0;
					1: cut = 63;
					2: cut = $urandom_range(0, 63);
					default: cut = $urandom_range(0, (len > 64 ? 64 : len) / 2);
				endcase
				set_reg(CFG_CUT_COUNT, cut[CFG_DATA_W-1:0]);
				for (i = 0; i < 56; i++) begin
					if (ph == 1 && seg == 2 && i == 28) begin
						await_results();
					end
					func = ($urandom_range(0, 99) < 5) ? FUNC_CLEAR : FUNC_ADD;
					send_item(func, pick_sample());
				end
			end
		end

		await_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (window.pending() != 0) begin
			window.flag($sformatf("%0d results never arrived", window.pending()));
		end
		if (window.mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
